@@ hw/rtl/swtm_pkg.sv @@
package swtm_pkg;

    // default storage parameters
    localparam int DEF_WINDOW_DEPTH = 64;
    localparam int DEF_SAMPLE_WIDTH = 16;

    // configuration register widths and reset values
    localparam int WSIZE_W     = 7;
    localparam int TRIM_W      = 5;
    localparam logic [WSIZE_W-1:0] WSIZE_RST = 7'd64;
    localparam logic [TRIM_W-1:0]  TRIM_RST  = 5'd1;

    // apb port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register index
    localparam logic REG_WINDOW_SIZE = 1'b0;
    localparam logic REG_TRIM_COUNT  = 1'b1;

endpackage

@@ hw/rtl/sliding_window_trimmed_mean.sv @@
// a full, valid window of w samples is ranked, its middle samples summed and the sum divided;
// otherwise no scan or division is run (w = window_size saturated to WINDOW_DEPTH)
// no new word is taken until the last one is through; the rank scan reads the sample memory
// once a cycle and the serial divider gives one quotient bit a cycle
// reset: asynchronous, active low; window empty, window_size 64, trim_count 1
module sliding_window_trimmed_mean
    import swtm_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_W-1:0]      paddr,
    input  logic [PDATA_W-1:0]      pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready,
    input  logic                    sample_valid,
    output logic                    sample_stall,
    input  logic [SAMPLE_WIDTH-1:0] sample,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic [SAMPLE_WIDTH-1:0] average,
    output logic                    window_full,
    output logic                    setting_error
);

    localparam int AW   = $clog2(WINDOW_DEPTH);
    localparam int CW   = $clog2(WINDOW_DEPTH + 1);
    localparam int SUMW = SAMPLE_WIDTH + CW;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD    = 7'b0000010,
        S_LOAD  = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_CHECK = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [WSIZE_W-1:0]      ws_reg;
    logic [TRIM_W-1:0]       tc_reg;
    logic [AW-1:0]           wp_reg, wp_next;
    logic [CW-1:0]           fill_reg, fill_next;
    logic [CW-1:0]           w_reg, w_next;
    logic [CW-1:0]           p_reg, p_next;
    logic [CW-1:0]           q_reg, q_next;
    logic [CW-1:0]           rank_reg, rank_next;
    logic [SAMPLE_WIDTH-1:0] v_reg, v_next;
    logic [SUMW-1:0]         sum_reg, sum_next;
    logic                    full_reg, full_next;
    logic                    err_reg, err_next;
    logic [SAMPLE_WIDTH-1:0] avg_reg, avg_next;
    logic                    ovalid_reg, ovalid_next;
    logic [SAMPLE_WIDTH-1:0] oavg_reg;
    logic                    ofull_reg;
    logic                    oerr_reg;
    logic [SAMPLE_WIDTH-1:0] mem [WINDOW_DEPTH];
    logic [SAMPLE_WIDTH-1:0] rd_data_reg;
    logic [AW-1:0]           rd_addr;
    logic [CW-1:0]           rd_idx;
    logic                    accept;
    logic                    cfg_wr;
    logic [CW-1:0]           w_eff;
    logic                    full_now;
    logic                    err_now;
    logic                    lt;
    logic                    in_middle;
    logic                    div_start;
    logic                    div_done;
    logic [SUMW-1:0]         div_quo;
    logic [CW-1:0]           mid_count;
    logic                    out_load;

    // window position (0 = newest) to ring address
    function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] wp,
                                                input logic [CW-1:0] idx);
        logic [AW+1:0] t;
        t = (AW+2)'(wp) + (AW+2)'(WINDOW_DEPTH - 1) - (AW+2)'(idx);
        if (t >= (AW+2)'(WINDOW_DEPTH))
        begin
            t = t - (AW+2)'(WINDOW_DEPTH);
        end
        return t[AW-1:0];
    endfunction

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[2])
            REG_WINDOW_SIZE: prdata = PDATA_W'(ws_reg);
            REG_TRIM_COUNT:  prdata = PDATA_W'(tc_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg <= WSIZE_RST;
            tc_reg <= TRIM_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_WINDOW_SIZE: ws_reg <= pwdata[WSIZE_W-1:0];
                REG_TRIM_COUNT:  tc_reg <= pwdata[TRIM_W-1:0];
                default:         ws_reg <= ws_reg;
            endcase
        end
    end

    // input handshake and window status for the incoming word
    assign sample_stall = (state_reg != S_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign w_eff        = (32'(ws_reg) > 32'(WINDOW_DEPTH)) ? CW'(WINDOW_DEPTH)
                                                          : CW'(ws_reg);
    assign fill_next    = (accept && (32'(fill_reg) < 32'(WINDOW_DEPTH)))
                          ? fill_reg + 1'b1 : fill_reg;
    assign full_now     = fill_next >= w_eff;
    assign err_now      = (2 * 32'(tc_reg)) >= 32'(w_eff);

    // shared comparator: rank of the held sample among the window
    assign lt        = (rd_data_reg < v_reg) || ((rd_data_reg == v_reg) && (q_reg < p_reg));
    assign in_middle = (32'(rank_reg) >= 32'(tc_reg))
                       && ((32'(rank_reg) + 32'(tc_reg)) < 32'(w_reg));
    assign mid_count = CW'(32'(w_reg) - 2 * 32'(tc_reg));
    assign out_load  = (state_reg == S_DONE) && (!ovalid_reg || !result_stall);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        w_next     = w_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        rank_next  = rank_reg;
        v_next     = v_reg;
        sum_next   = sum_reg;
        full_next  = full_reg;
        err_next   = err_reg;
        avg_next   = avg_reg;
        rd_idx     = '0;
        div_start  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    wp_next   = (32'(wp_reg) == WINDOW_DEPTH - 1) ? '0 : wp_reg + 1'b1;
                    w_next    = w_eff;
                    full_next = full_now;
                    err_next  = err_now;
                    p_next    = '0;
                    sum_next  = '0;
                    avg_next  = '0;
                    state_next = (full_now && !err_now) ? S_RD : S_DONE;
                end
            end
            S_RD:
            begin
                rd_idx     = p_reg;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                v_next     = rd_data_reg;
                rd_idx     = '0;
                q_next     = '0;
                rank_next  = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                rank_next = rank_reg + CW'(lt);
                if (q_reg == w_reg - 1'b1)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    q_next = q_reg + 1'b1;
                    rd_idx = q_reg + 1'b1;
                end
            end
            S_CHECK:
            begin
                if (in_middle)
                begin
                    sum_next = sum_reg + SUMW'(v_reg);
                end
                p_next = p_reg + 1'b1;
                if (p_reg + 1'b1 == w_reg)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    avg_next   = div_quo[SAMPLE_WIDTH-1:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rd_addr = ring_addr(wp_reg, rd_idx);

    // sample memory
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem[wp_reg] <= sample;
        end
        rd_data_reg <= mem[rd_addr];
    end

    swtm_div #(
        .N (SUMW),
        .M (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (mid_count),
        .done     (div_done),
        .quotient (div_quo)
    );

    // output word register
    assign ovalid_next = out_load ? 1'b1 : (ovalid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            wp_reg     <= '0;
            fill_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wp_reg     <= wp_next;
            fill_reg   <= fill_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg    <= w_next;
        p_reg    <= p_next;
        q_reg    <= q_next;
        rank_reg <= rank_next;
        v_reg    <= v_next;
        sum_reg  <= sum_next;
        full_reg <= full_next;
        err_reg  <= err_next;
        avg_reg  <= avg_next;
        if (out_load)
        begin
            oavg_reg  <= avg_reg;
            ofull_reg <= full_reg;
            oerr_reg  <= err_reg;
        end
    end

    assign result_valid  = ovalid_reg;
    assign average       = oavg_reg;
    assign window_full   = ofull_reg;
    assign setting_error = oerr_reg;

endmodule

@@ hw/rtl/swtm_div.sv @@
module swtm_div
    import swtm_pkg::*;
#(
    parameter int N = 22,
    parameter int M = 7
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [M-1:0] divisor,
    output logic         done,
    output logic [N-1:0] quotient
);

    localparam int CNTW = $clog2(N + 1);

    logic [M-1:0]    rem_reg;
    logic [M-1:0]    rem_next;
    logic [N-1:0]    quo_reg;
    logic [N-1:0]    quo_next;
    logic [M-1:0]    dvs_reg;
    logic [M-1:0]    dvs_next;
    logic [CNTW-1:0] cnt_reg;
    logic [CNTW-1:0] cnt_next;
    logic            done_reg;
    logic            done_next;
    logic [M:0]      trial;
    logic            ge;

    // one restoring step per cycle
    always_comb
    begin
        trial     = {rem_reg, quo_reg[N-1]};
        ge        = trial >= {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = CNTW'(N);
        end
        else if (cnt_reg != '0)
        begin
            rem_next = ge ? M'(trial - {1'b0, dvs_reg}) : trial[M-1:0];
            quo_next = {quo_reg[N-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
